@@ rtl/ifmt_pkg.sv @@
package ifmt_pkg;

  // Argument width and field length limit
  localparam int VALUE_BITS = 32;
  localparam int MAX_WIDTH  = 63;

  // Port field widths
  localparam int KIND_W  = 3;
  localparam int FIELD_W = 6;
  localparam int CHAR_W  = 8;

  // in_tdata layout, lowest bit first
  localparam int VALUE_FIELD_W = 32;
  localparam int TD_PZ         = VALUE_FIELD_W;
  localparam int TD_LJ         = TD_PZ + 1;
  localparam int TD_FS         = TD_LJ + 1;
  localparam int TD_SS         = TD_FS + 1;
  localparam int TD_ALT        = TD_SS + 1;
  localparam int TD_WID        = TD_ALT + 1;
  localparam int TD_PREC       = TD_WID + FIELD_W;
  localparam int TD_USED       = TD_PREC + FIELD_W;
  localparam int IN_TDATA_W    = ((TD_USED + 7) / 8) * 8;

  // Derived sizes
  localparam int CW      = $clog2(MAX_WIDTH + 1);
  localparam int DIG_MAX = (VALUE_BITS + 2) / 3;
  localparam int DIG_IW  = $clog2(DIG_MAX);
  localparam int DIG_CW  = $clog2(DIG_MAX + 1);
  localparam int BIT_CW  = $clog2(VALUE_BITS);
  localparam int DEC_RADIX = 10;

  // Characters
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;

  typedef enum logic [KIND_W-1:0] {
    K_DEC  = 3'd0,
    K_UNS  = 3'd1,
    K_HEXL = 3'd2,
    K_HEXU = 3'd3,
    K_OCT  = 3'd4,
    K_CHR  = 3'd5
  } fmt_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CONV,
    ST_SIZE,
    ST_EMIT
  } fmt_state_t;

  // One 4-bit digit per entry, least significant digit at index 0
  typedef logic [DIG_MAX-1:0][3:0] dig_vec_t;

  // Segment boundaries of one field, as character positions
  typedef struct packed {
    logic [CW-1:0]     b_lpad;
    logic [CW-1:0]     b_sign;
    logic [CW-1:0]     b_pre;
    logic [CW-1:0]     b_fill;
    logic [CW-1:0]     b_dig;
    logic [CW-1:0]     total;
    logic              upper;
    logic              is_char;
    logic [CHAR_W-1:0] sign_ch;
    logic [CHAR_W-1:0] fill_ch;
    logic [CHAR_W-1:0] chr;
  } ifmt_layout_t;

  // Clamp a width or precision to the field limit
  function automatic logic [CW-1:0] sat_len(input logic [FIELD_W-1:0] v);
    if (v > FIELD_W'(MAX_WIDTH)) begin
      return CW'(MAX_WIDTH);
    end
    return v[CW-1:0];
  endfunction

endpackage

@@ rtl/ifmt_b2d.sv @@
module ifmt_b2d (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [ifmt_pkg::VALUE_BITS-1:0] mag,
  output logic                            busy,
  output logic                            done,
  output ifmt_pkg::dig_vec_t              digits
);
  import ifmt_pkg::*;

  logic [VALUE_BITS-1:0] sh_r;
  logic [BIT_CW-1:0]     cnt_r;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  dig_vec_t              bcd_r, bcd_adj;
  logic [DIG_MAX*4-1:0]  bcd_flat;

  // Add-3 correction on every BCD digit before the shift
  always_comb begin
    for (int i = 0; i < DIG_MAX; i++) begin
      bcd_adj[i] = (bcd_r[i] >= 4'd5) ? (bcd_r[i] + 4'd3) : bcd_r[i];
    end
  end

  assign bcd_flat = bcd_adj;

  // Control: one argument bit per cycle, MSB first
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && cnt_r == '0) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Shift datapath
  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= mag;
      bcd_r <= '0;
      cnt_r <= BIT_CW'(VALUE_BITS - 1);
    end else if (busy_r) begin
      sh_r  <= {sh_r[VALUE_BITS-2:0], 1'b0};
      bcd_r <= {bcd_flat[DIG_MAX*4-2:0], sh_r[VALUE_BITS-1]};
      cnt_r <= cnt_r - BIT_CW'(1);
    end
  end

  assign busy   = busy_r;
  assign done   = done_r;
  assign digits = bcd_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("converter not busy after start");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("converter done while still shifting");

  a_last_shift: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && cnt_r == '0 |=> done_r)
    else $error("converter did not finish after its last bit");

endmodule

@@ rtl/ifmt_emit.sv @@
module ifmt_emit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  ifmt_pkg::ifmt_layout_t        lay,
  input  ifmt_pkg::dig_vec_t            dig,
  output logic                          busy,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ifmt_pkg::CHAR_W-1:0]   out_char,
  output logic                          out_last
);
  import ifmt_pkg::*;

  logic [CW-1:0]     pos_r, pos_nxt;
  logic              busy_r, busy_nxt;
  logic              vld_r, vld_nxt;
  logic [CHAR_W-1:0] char_r;
  logic              last_r;
  logic              load, is_last;
  logic [CW-1:0]     di;
  logic [3:0]        dg;
  logic [CHAR_W-1:0] dig_ch, ch;

  assign load    = busy_r && (!vld_r || out_tready);
  assign is_last = (pos_r == lay.total - CW'(1));

  // Digit for this position, most significant first
  always_comb begin
    di = lay.b_dig - pos_r - CW'(1);
    dg = 4'd0;
    if (di < CW'(DIG_MAX)) begin
      dg = dig[di[DIG_IW-1:0]];
    end
    if (dg < 4'(DEC_RADIX)) begin
      dig_ch = CH_ZERO + {4'd0, dg};
    end else begin
      dig_ch = (lay.upper ? CH_UA : CH_LA) + {4'd0, dg} - 8'(DEC_RADIX);
    end
  end

  // Character at the current position
  always_comb begin
    if (pos_r < lay.b_lpad) begin
      ch = CH_SPACE;
    end else if (pos_r < lay.b_sign) begin
      ch = lay.sign_ch;
    end else if (pos_r < lay.b_pre) begin
      ch = (pos_r == lay.b_sign) ? CH_ZERO : (lay.upper ? CH_UX : CH_LX);
    end else if (pos_r < lay.b_fill) begin
      ch = lay.fill_ch;
    end else if (pos_r < lay.b_dig) begin
      ch = lay.is_char ? lay.chr : dig_ch;
    end else begin
      ch = CH_SPACE;
    end
  end

  // Position counter and output register control
  always_comb begin
    pos_nxt  = pos_r;
    busy_nxt = busy_r;
    vld_nxt  = vld_r && !out_tready;
    if (start) begin
      pos_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (load) begin
      pos_nxt  = pos_r + CW'(1);
      busy_nxt = !is_last;
    end
    if (load) begin
      vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      busy_r <= 1'b0;
      vld_r  <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      busy_r <= busy_nxt;
      vld_r  <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= ch;
      last_r <= is_last;
    end
  end

  assign busy       = busy_r;
  assign out_tvalid = vld_r;
  assign out_char   = char_r;
  assign out_last   = last_r;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> pos_r < lay.total)
    else $error("character position past field end");

  a_last_stops: assert property (@(posedge clk) disable iff (!rst_n)
    load && is_last |=> !busy_r && vld_r && last_r)
    else $error("field did not close on its last character");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && !out_tready |=> vld_r && $stable(char_r) && $stable(last_r))
    else $error("output transaction changed while stalled");

endmodule

@@ rtl/integer_field_formatter.sv @@
// Sequence: x, X, o and c go from the accepted transaction through LOAD, SIZE and EMIT;
// d and u add CONV after LOAD, waiting on the bit-serial decimal converter.
// Throughput: one field at a time, one character per cycle on out_ while out_tready is high.
// Reset: synchronous, active low; clears the sequencer, converter and output valid,
// after which in_tready is high.
module integer_field_formatter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // value[31:0], pad_zero, left_just, force_sign, space_sign, alt_form,
  // min_width[5:0], precision[5:0], zero fill
  input  logic [ifmt_pkg::IN_TDATA_W-1:0] in_tdata,
  // kind[2:0]
  input  logic [ifmt_pkg::KIND_W-1:0]     in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_char[7:0]
  output logic [ifmt_pkg::CHAR_W-1:0]     out_tdata,
  output logic                            out_tlast
);
  import ifmt_pkg::*;

  fmt_state_t            state_r, state_nxt;
  fmt_kind_t             kind_in, kind_r;
  logic [VALUE_BITS-1:0] in_val, mag_in, mag_r;
  logic                  neg, num_sign_kind, accept;
  logic [CHAR_W-1:0]     sign_ch_in, sign_ch_r;
  logic                  sign_len_in, sign_len_r;
  logic                  pad_zero_r, left_just_r, alt_r;
  logic [CW-1:0]         width_r, prec_r;
  dig_vec_t              dig_r, dig_direct, b2d_dig;
  ifmt_layout_t          lay_r, lay_nxt;
  logic                  is_decimal;
  logic                  b2d_start, b2d_busy, b2d_done;
  logic                  direct_load, emit_start, emit_busy;
  logic [DIG_MAX*4-1:0]  mag4;
  logic [DIG_MAX*3-1:0]  mag3;

  // Input decode and sign/magnitude
  assign accept = in_tvalid && in_tready;
  assign in_val = in_tdata[VALUE_BITS-1:0];

  always_comb begin
    kind_in = (in_tuser > KIND_W'(K_CHR)) ? K_UNS : fmt_kind_t'(in_tuser);
    num_sign_kind = (kind_in == K_DEC) || (kind_in == K_UNS);
    neg = (kind_in == K_DEC) && in_val[VALUE_BITS-1];
    mag_in = neg ? (~in_val + VALUE_BITS'(1)) : in_val;
    sign_ch_in  = CH_SPACE;
    sign_len_in = 1'b0;
    if (neg) begin
      sign_ch_in  = CH_MINUS;
      sign_len_in = 1'b1;
    end else if (num_sign_kind && in_tdata[TD_FS]) begin
      sign_ch_in  = CH_PLUS;
      sign_len_in = 1'b1;
    end else if (num_sign_kind && in_tdata[TD_SS]) begin
      sign_len_in = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r      <= kind_in;
      mag_r       <= mag_in;
      sign_ch_r   <= sign_ch_in;
      sign_len_r  <= sign_len_in;
      pad_zero_r  <= in_tdata[TD_PZ];
      left_just_r <= in_tdata[TD_LJ];
      alt_r       <= in_tdata[TD_ALT];
      width_r     <= sat_len(in_tdata[TD_WID +: FIELD_W]);
      prec_r      <= sat_len(in_tdata[TD_PREC +: FIELD_W]);
    end
  end

  assign is_decimal = (kind_r == K_DEC) || (kind_r == K_UNS);

  // Hex and octal digits are plain bit groups
  always_comb begin
    mag4 = (DIG_MAX * 4)'(mag_r);
    mag3 = (DIG_MAX * 3)'(mag_r);
    for (int i = 0; i < DIG_MAX; i++) begin
      if (kind_r == K_OCT) begin
        dig_direct[i] = {1'b0, mag3[3*i +: 3]};
      end else begin
        dig_direct[i] = mag4[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (direct_load) begin
      dig_r <= dig_direct;
    end else if (b2d_done) begin
      dig_r <= b2d_dig;
    end
  end

  // Field layout from the digit count, width and precision
  always_comb begin
    logic [DIG_IW-1:0] topi;
    logic [DIG_CW-1:0] ndig;
    logic [1:0]        pre_len;
    logic [CW-1:0]     body, prec0, precf, widthf, lpad;
    topi = '0;
    for (int i = 0; i < DIG_MAX; i++) begin
      if (dig_r[i] != 4'd0) begin
        topi = DIG_IW'(i);
      end
    end
    ndig = (kind_r == K_CHR) ? DIG_CW'(1) : (DIG_CW'(topi) + DIG_CW'(1));
    pre_len = 2'd0;
    if (alt_r && (kind_r == K_HEXL || kind_r == K_HEXU)) begin
      pre_len = 2'd2;
    end else if (alt_r && kind_r == K_OCT) begin
      pre_len = 2'd1;
    end
    body   = CW'(sign_len_r) + CW'(pre_len) + CW'(ndig);
    prec0  = (prec_r == '0 && pad_zero_r && !left_just_r) ? width_r : prec_r;
    precf  = (prec0 < body) ? body : prec0;
    widthf = (width_r < precf) ? precf : width_r;
    lpad   = left_just_r ? '0 : (widthf - precf);
    lay_nxt.b_lpad  = lpad;
    lay_nxt.b_sign  = lpad + CW'(sign_len_r);
    lay_nxt.b_pre   = lpad + CW'(sign_len_r) + CW'(pre_len);
    lay_nxt.b_fill  = lpad + precf - CW'(ndig);
    lay_nxt.b_dig   = lpad + precf;
    lay_nxt.total   = widthf;
    lay_nxt.upper   = (kind_r == K_HEXU);
    lay_nxt.is_char = (kind_r == K_CHR);
    lay_nxt.sign_ch = sign_ch_r;
    lay_nxt.fill_ch = (kind_r == K_CHR) ? CH_SPACE : CH_ZERO;
    lay_nxt.chr     = mag_r[CHAR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (emit_start) begin
      lay_r <= lay_nxt;
    end
  end

  // Sequencer: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        state_nxt = is_decimal ? ST_CONV : ST_SIZE;
      end
      ST_CONV: begin
        if (b2d_done) state_nxt = ST_SIZE;
      end
      ST_SIZE: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!emit_busy) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_tready   = 1'b0;
    b2d_start   = 1'b0;
    direct_load = 1'b0;
    emit_start  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
      end
      ST_LOAD: begin
        b2d_start   = is_decimal;
        direct_load = !is_decimal;
      end
      ST_SIZE: begin
        emit_start = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  ifmt_b2d u_b2d (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (b2d_start),
    .mag    (mag_r),
    .busy   (b2d_busy),
    .done   (b2d_done),
    .digits (b2d_dig)
  );

  ifmt_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (emit_start),
    .lay        (lay_r),
    .dig        (dig_r),
    .busy       (emit_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_char   (out_tdata),
    .out_last   (out_tlast)
  );

  a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_LOAD)
    else $error("accepted transaction not loaded");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !emit_busy && !b2d_busy)
    else $error("idle while a field is still in progress");

  a_conv_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CONV |-> b2d_busy || b2d_done)
    else $error("waiting on a converter that is not running");

endmodule

@@ tb/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ifmt_pkg::*;

  // Flag bits as passed to queue_field: {alt, space, plus, left, zero}
  localparam logic [4:0] F_NONE  = 5'b00000;
  localparam logic [4:0] F_ZERO  = 5'b00001;
  localparam logic [4:0] F_LEFT  = 5'b00010;
  localparam logic [4:0] F_PLUS  = 5'b00100;
  localparam logic [4:0] F_SPACE = 5'b01000;
  localparam logic [4:0] F_ALT   = 5'b10000;

  // Undefined conversion codes, formatted as unsigned
  localparam logic [KIND_W-1:0] K_RSVD6 = 3'd6;
  localparam logic [KIND_W-1:0] K_RSVD7 = 3'd7;

  localparam int IDLE_LIMIT = 4000;
  localparam int MAX_GAP    = 8;

  typedef struct {
    logic [KIND_W-1:0]     kind;
    logic [VALUE_BITS-1:0] value;
    logic                  pad_zero;
    logic                  left_just;
    logic                  force_sign;
    logic                  space_sign;
    logic                  alt_form;
    logic [FIELD_W-1:0]    min_width;
    logic [FIELD_W-1:0]    precision;
    int unsigned           gap;
    bit                    drain;
  } field_req_t;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } field_char_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [KIND_W-1:0]     in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [CHAR_W-1:0]     out_tdata;
  logic                  out_tlast;

  field_req_t  pending_fields[$];
  field_char_t exp_chars[$];
  field_req_t  cur_req;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned quiet_results;
  int unsigned idle_cycles;
  int unsigned errors = 0;
  int unsigned char_count = 0;

  integer_field_formatter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #1 clk = ~clk;

  // Field request to in_tdata layout
  function automatic logic [IN_TDATA_W-1:0] pack_field(input field_req_t r);
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    d[VALUE_FIELD_W-1:0]   = r.value;
    d[TD_PZ]               = r.pad_zero;
    d[TD_LJ]               = r.left_just;
    d[TD_FS]               = r.force_sign;
    d[TD_SS]               = r.space_sign;
    d[TD_ALT]              = r.alt_form;
    d[TD_WID +: FIELD_W]   = r.min_width;
    d[TD_PREC +: FIELD_W]  = r.precision;
    return d;
  endfunction

  // Work out the characters of one field and queue them as expected output
  function automatic void format_field(input field_req_t r);
    logic [KIND_W-1:0]     k;
    logic [VALUE_BITS-1:0] mag;
    logic [VALUE_BITS-1:0] radix;
    logic [3:0]            dv;
    logic [CHAR_W-1:0]     sign_ch;
    logic [CHAR_W-1:0]     pre_ch2;
    logic [CHAR_W-1:0]     fill_ch;
    logic [CHAR_W-1:0]     digs[$];
    logic [CHAR_W-1:0]     line[$];
    int                    sign_len;
    int                    pre_len;
    int                    body_len;
    int                    wid;
    int                    prec;
    bit                    numeric;
    bit                    upper;
    field_char_t           fc;

    k = r.kind;
    if (k > K_CHR) begin
      k = K_UNS;
    end
    wid  = (r.min_width > MAX_WIDTH) ? MAX_WIDTH : int'(r.min_width);
    prec = (r.precision > MAX_WIDTH) ? MAX_WIDTH : int'(r.precision);
    sign_len = 0;
    pre_len  = 0;
    sign_ch  = CH_SPACE;
    pre_ch2  = CH_LX;
    numeric  = 1'b1;
    upper    = 1'b0;
    radix    = DEC_RADIX;
    mag      = r.value;

    if (k == K_CHR) begin
      numeric = 1'b0;
      digs.push_back(r.value[CHAR_W-1:0]);
    end else begin
      // sign: minus for negative d, then plus or blank for d and u
      if (k == K_DEC && r.value[VALUE_BITS-1]) begin
        mag      = -r.value;
        sign_ch  = CH_MINUS;
        sign_len = 1;
      end
      if ((k == K_DEC || k == K_UNS) && sign_len == 0) begin
        if (r.force_sign) begin
          sign_ch  = CH_PLUS;
          sign_len = 1;
        end else if (r.space_sign) begin
          sign_ch  = CH_SPACE;
          sign_len = 1;
        end
      end
      if (k == K_HEXL || k == K_HEXU) begin
        radix = 16;
        upper = (k == K_HEXU);
        if (r.alt_form) begin
          pre_len = 2;
          pre_ch2 = upper ? CH_UX : CH_LX;
        end
      end else if (k == K_OCT) begin
        radix = 8;
        if (r.alt_form) begin
          pre_len = 1;
        end
      end
      // digits, most significant first
      do begin
        dv = 4'(mag % radix);
        if (dv < 10) begin
          digs.push_front(CH_ZERO + CHAR_W'(dv));
        end else begin
          digs.push_front((upper ? CH_UA : CH_LA) + CHAR_W'(dv - 10));
        end
        mag = mag / radix;
      end while (mag != 0);
    end

    body_len = sign_len + pre_len + digs.size();
    if (prec == 0 && r.pad_zero && !r.left_just) begin
      prec = wid;
    end
    if (prec < body_len) begin
      prec = body_len;
    end
    if (wid < prec) begin
      wid = prec;
    end
    fill_ch = numeric ? CH_ZERO : CH_SPACE;

    if (!r.left_just) begin
      repeat (wid - prec) line.push_back(CH_SPACE);
    end
    if (sign_len != 0) begin
      line.push_back(sign_ch);
    end
    if (pre_len >= 1) begin
      line.push_back(CH_ZERO);
    end
    if (pre_len == 2) begin
      line.push_back(pre_ch2);
    end
    repeat (prec - body_len) line.push_back(fill_ch);
    foreach (digs[i]) begin
      line.push_back(digs[i]);
    end
    if (r.left_just) begin
      repeat (wid - prec) line.push_back(CH_SPACE);
    end

    foreach (line[i]) begin
      fc.ch   = line[i];
      fc.last = (i == line.size() - 1);
      exp_chars.push_back(fc);
    end
  endfunction

  task automatic queue_field(input logic [KIND_W-1:0] k, input logic [VALUE_BITS-1:0] v,
                             input logic [4:0] flags, input int w, input int p,
                             input int unsigned gap, input bit drain);
    field_req_t r;
    r.kind       = k;
    r.value      = v;
    r.pad_zero   = flags[0];
    r.left_just  = flags[1];
    r.force_sign = flags[2];
    r.space_sign = flags[3];
    r.alt_form   = flags[4];
    r.min_width  = FIELD_W'(w);
    r.precision  = FIELD_W'(p);
    r.gap        = gap;
    r.drain      = drain;
    pending_fields.push_back(r);
  endtask

  // Input driver: presents queued requests, idles per request, holds for drains
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left  <= 0;
    end else if (in_tvalid) begin
      if (in_tready) begin
        format_field(cur_req);
        if (pending_fields.size() != 0 && pending_fields[0].gap == 0 &&
            !pending_fields[0].drain) begin
          cur_req = pending_fields.pop_front();
          in_tdata <= pack_field(cur_req);
          in_tuser <= cur_req.kind;
        end else begin
          in_tvalid <= 1'b0;
          if (pending_fields.size() != 0) begin
            gap_left <= pending_fields[0].gap;
          end
        end
      end
    end else if (pending_fields.size() != 0) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
      end else if (!pending_fields[0].drain || exp_chars.size() == 0) begin
        cur_req = pending_fields.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= pack_field(cur_req);
        in_tuser  <= cur_req.kind;
      end
    end
  end

  // Output monitor: checks each character transaction, stalls at random
  always @(posedge clk) begin
    field_char_t fc;
    int unsigned st;
    if (!rst_n) begin
      out_tready    <= 1'b0;
      stall_left    <= 0;
      quiet_results <= 0;
    end else if (out_tready) begin
      if (out_tvalid) begin
        char_count <= char_count + 1;
        if (exp_chars.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) begin
            $display("ERROR char %0d: unexpected char 0x%02h last=%0b", char_count,
                     out_tdata, out_tlast);
          end
        end else begin
          fc = exp_chars.pop_front();
          if (out_tdata !== fc.ch || out_tlast !== fc.last) begin
            errors <= errors + 1;
            if (errors < 10) begin
              $display("ERROR char %0d: expected 0x%02h last=%0b, got 0x%02h last=%0b",
                       char_count, fc.ch, fc.last, out_tdata, out_tlast);
            end
          end
        end
        // quiet stretches with no back-pressure now and then
        if (quiet_results != 0) begin
          st = 0;
          quiet_results <= quiet_results - 1;
        end else if ($urandom_range(0, 24) == 0) begin
          st = 0;
          quiet_results <= 40;
        end else begin
          st = $urandom_range(0, MAX_GAP);
        end
        if (st != 0) begin
          out_tready <= 1'b0;
          stall_left <= st;
        end
      end
    end else begin
      if (stall_left <= 1) begin
        out_tready <= 1'b1;
      end
      stall_left <= (stall_left == 0) ? 0 : stall_left - 1;
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("ERROR: no transaction for %0d cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int unsigned quiet;
    int unsigned gap;
    logic [VALUE_BITS-1:0] v;
    logic [KIND_W-1:0] k;
    int w;
    int p;

    // Directed: extremes, every conversion and the special cases
    queue_field(K_DEC,  32'd0,        F_NONE,           0,  0,  0, 1'b0);
    queue_field(K_DEC,  32'h80000000, F_NONE,           0,  0,  $urandom_range(0, 8), 1'b0);
    queue_field(K_DEC,  32'h7FFFFFFF, F_PLUS,           12, 0,  0, 1'b0);
    queue_field(K_DEC,  32'hFFFFFFFF, F_PLUS | F_SPACE, 5,  4,  $urandom_range(0, 8), 1'b0);
    queue_field(K_DEC,  32'd42,       F_PLUS | F_SPACE, 0,  0,  0, 1'b0);
    queue_field(K_DEC,  32'd7,        F_SPACE | F_ALT,  6,  3,  $urandom_range(0, 8), 1'b0);
    queue_field(K_UNS,  32'hFFFFFFFF, F_PLUS,           0,  0,  0, 1'b0);
    queue_field(K_UNS,  32'd9,        F_SPACE | F_ZERO, 8,  0,  $urandom_range(0, 8), 1'b1);
    queue_field(K_HEXL, 32'd0,        F_ALT,            0,  0,  0, 1'b0);
    queue_field(K_HEXU, 32'hDEADBEEF, F_ALT | F_ZERO,   20, 0,  0, 1'b0);
    queue_field(K_HEXL, 32'hCAFEF00D, F_PLUS | F_SPACE, 3,  0,  $urandom_range(0, 8), 1'b0);
    queue_field(K_OCT,  32'd0,        F_ALT,            0,  0,  0, 1'b0);
    queue_field(K_OCT,  32'hFFFFFFFF, F_ALT | F_LEFT,   16, 14, $urandom_range(0, 8), 1'b0);
    queue_field(K_CHR,  32'h41,       F_LEFT | F_ALT,   5,  0,  0, 1'b0);
    queue_field(K_CHR,  32'hFFFFFF00, F_PLUS,           0,  0,  $urandom_range(0, 8), 1'b0);
    queue_field(K_CHR,  32'h7E,       F_ZERO,           6,  4,  0, 1'b0);
    queue_field(K_CHR,  32'hFF,       F_ZERO,           3,  0,  $urandom_range(0, 8), 1'b1);
    queue_field(K_RSVD6, 32'd1234,    F_PLUS,           7,  0,  0, 1'b0);
    queue_field(K_RSVD7, 32'hFFFFFFFF, F_SPACE | F_ALT, 0,  0,  $urandom_range(0, 8), 1'b0);
    queue_field(K_DEC,  32'hFFFFFF85, F_LEFT,           63, 0,  0, 1'b0);
    queue_field(K_HEXL, 32'd255,      F_NONE,           0,  63, $urandom_range(0, 8), 1'b0);
    queue_field(K_DEC,  32'd5,        F_ZERO | F_LEFT,  10, 0,  0, 1'b0);
    queue_field(K_DEC,  32'hFFFFFFFB, F_ZERO,           10, 4,  $urandom_range(0, 8), 1'b0);
    queue_field(K_UNS,  32'd3,        F_ZERO,           63, 0,  0, 1'b0);
    queue_field(K_OCT,  32'd8,        F_ALT | F_ZERO,   63, 63, $urandom_range(0, 8), 1'b1);

    // Random fields, mostly small widths with occasional extremes
    quiet = 0;
    for (int i = 0; i < 195; i++) begin
      k = ($urandom_range(0, 19) == 0) ? KIND_W'($urandom_range(6, 7))
                                        : KIND_W'($urandom_range(0, 5));
      case ($urandom_range(0, 5))
        0: v = $urandom_range(0, 20);
        1: v = -VALUE_BITS'($urandom_range(1, 300));
        2: v = 32'hFFFFFFFF - $urandom_range(0, 3);
        3: v = 32'h80000000 + $urandom_range(0, 3);
        default: v = $urandom;
      endcase
      w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 16);
      case ($urandom_range(0, 9))
        0: p = $urandom_range(0, 63);
        1, 2, 3, 4: p = $urandom_range(0, 16);
        default: p = 0;
      endcase
      if (quiet != 0) begin
        gap = 0;
        quiet--;
      end else if ($urandom_range(0, 15) == 0) begin
        gap = 0;
        quiet = 20;
      end else begin
        gap = $urandom_range(0, MAX_GAP);
      end
      queue_field(k, v, 5'($urandom_range(0, 31)), w, p, gap, (i % 40) == 39);
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_fields.size() != 0 || in_tvalid || exp_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (VALUE_BITS + 10) @(posedge clk);

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
